// ===== design/dfir_pkg.sv =====
// dfir_pkg: shared types and constants for the decimating fir filter
// sequencer states, beat mode codes and configuration register map
// no dependencies
`timescale 1ns / 1ps

package dfir_pkg;

  // configuration port geometry
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 16;

  // register widths fixed by the register map
  localparam int DECIM_BITS    = 8;
  localparam int TAPS_CFG_BITS = 9;
  localparam int COEF_IDX_BITS = 8;

  // register indexes
  localparam logic [CFG_ADDR_BITS-1:0] CFG_DECIM = CFG_ADDR_BITS'(0);
  localparam logic [CFG_ADDR_BITS-1:0] CFG_TAPS  = CFG_ADDR_BITS'(1);

  // register reset values
  localparam logic [DECIM_BITS-1:0]    DECIM_RESET = DECIM_BITS'(10);
  localparam logic [TAPS_CFG_BITS-1:0] TAPS_RESET  = TAPS_CFG_BITS'(151);

  // input beat mode codes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_OUT
  } fsm_state_t;

endpackage

// ===== design/dfir_ram.sv =====
// dfir_ram: generic single write port, single read port ram
// read data is registered; no dependencies
`timescale 1ns / 1ps

module dfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/decimating_fir_filter.sv =====
// a coefficient beat or a sample beat that yields no output leaves in_ready high
// an output sample holds in_ready low from its accept while the one shared multiply-accumulate
// folds in one tap per cycle, taps being the taps register capped at MAX_TAPS (no taps skips
// this), then while the product pipeline drains and the previous result waits to leave
// a finished result waits in the output register while new beats are accepted
// reset (rst_n low, synchronous): delay line reads as zero, phase 0, registers to defaults
`timescale 1ns / 1ps

module decimating_fir_filter #(
  parameter int MAX_TAPS    = 256,
  parameter int SAMPLE_BITS = 16,
  parameter int ACC_BITS    = 40
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_mode,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  input  logic [dfir_pkg::COEF_IDX_BITS-1:0]   in_coef_index,
  input  logic signed [SAMPLE_BITS-1:0]        in_coef_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]        out_filtered,
  output logic                                 out_saturated,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dfir_pkg::CFG_ADDR_BITS-1:0]   cfg_index,
  input  logic [dfir_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  import dfir_pkg::*;

  localparam int AW = $clog2(MAX_TAPS);
  localparam int CW = $clog2(MAX_TAPS + 1);
  localparam int PW = 2 * SAMPLE_BITS;
  localparam int SW = ((ACC_BITS > PW) ? ACC_BITS : PW) + 1;
  localparam int IW = ((AW > COEF_IDX_BITS) ? AW : COEF_IDX_BITS) + 1;
  localparam int TW = (CW > TAPS_CFG_BITS) ? CW : TAPS_CFG_BITS;

  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_TAPS);

  localparam logic signed [SW-1:0] AMAX_W = SW'({1'b0, {(ACC_BITS-1){1'b1}}});
  localparam logic signed [SW-1:0] AMIN_W = ~AMAX_W;
  localparam logic signed [ACC_BITS:0] SMAX_W =
    (ACC_BITS+1)'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [ACC_BITS:0] SMIN_W = ~SMAX_W;
  localparam logic [ACC_BITS:0] RND_HALF = (ACC_BITS+1)'(1) << (SAMPLE_BITS - 2);

  fsm_state_t state_r, state_nxt;

  logic [DECIM_BITS-1:0]    decim_r;
  logic [TAPS_CFG_BITS-1:0] taps_cfg_r;
  logic [AW-1:0]            wp_r;
  logic [CW-1:0]            fill_r;
  logic [DECIM_BITS-1:0]    phase_r;
  logic [AW-1:0]            ptr_r;
  logic [CW-1:0]            k_r;
  logic [CW-1:0]            taps_r;
  logic                     s1_v_r, s1_ok_r, s2_v_r;
  logic signed [PW-1:0]     prod_r;
  logic signed [ACC_BITS-1:0] acc_r;
  logic                     sat_r;
  logic                     out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_filt_r;
  logic                     out_sat_r;

  logic in_fire, smp_fire, coef_fire, coef_ok, emit, start;
  logic cfg_fire, decim_wr, taps_wr;
  logic issue, load_out;
  logic [DECIM_BITS-1:0] dec_eff;
  logic [DECIM_BITS:0]   phase_inc;
  logic [TW-1:0]         taps_wide;
  logic [CW-1:0]         taps_eff;
  logic signed [SAMPLE_BITS-1:0] dl_rdata, cf_rdata;
  logic signed [PW-1:0]  mul_w;
  logic signed [SW-1:0]  sum_w;
  logic                  acc_hi, acc_lo;
  logic signed [ACC_BITS-1:0] acc_nxt;
  logic signed [ACC_BITS:0]   rnd_sum, rnd_shift;
  logic                  rnd_hi, rnd_lo;
  logic signed [SAMPLE_BITS-1:0] res;

  // handshakes
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign smp_fire  = in_fire && (in_mode == MODE_SAMPLE);
  assign coef_fire = in_fire && (in_mode == MODE_COEF);
  assign coef_ok   = IW'(in_coef_index) < IW'(MAX_TAPS);
  assign cfg_fire  = cfg_valid && cfg_ready;

  // register decode
  always_comb begin
    decim_wr = 1'b0;
    taps_wr  = 1'b0;
    if (cfg_fire) begin
      unique case (cfg_index)
        CFG_DECIM: decim_wr = 1'b1;
        CFG_TAPS:  taps_wr  = 1'b1;
        default: ;
      endcase
    end
  end

  // decimation phase and tap count
  assign dec_eff   = (decim_r == '0) ? DECIM_BITS'(1) : decim_r;
  assign phase_inc = {1'b0, phase_r} + (DECIM_BITS+1)'(1);
  assign emit      = (phase_r == '0);
  assign start     = smp_fire && emit;
  assign taps_wide = (TW'(taps_cfg_r) > TW'(MAX_TAPS)) ? TW'(MAX_TAPS) : TW'(taps_cfg_r);
  assign taps_eff  = taps_wide[CW-1:0];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    issue     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = (taps_eff == '0) ? S_OUT : S_MAC;
      end
      S_MAC: begin
        issue = 1'b1;
        if (k_r == taps_r - CW'(1)) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!s1_v_r && !s2_v_r) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // delay line, circular; each sample beat writes at the write pointer and advances it
  dfir_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_delay_ram (
    .clk     (clk),
    .wr_en   (smp_fire),
    .wr_addr (wp_r),
    .wr_data (in_sample),
    .rd_en   (issue),
    .rd_addr (ptr_r),
    .rd_data (dl_rdata)
  );

  // coefficient store
  dfir_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_coef_ram (
    .clk     (clk),
    .wr_en   (coef_fire && coef_ok),
    .wr_addr (AW'(in_coef_index)),
    .wr_data (in_coef_value),
    .rd_en   (issue),
    .rd_addr (k_r[AW-1:0]),
    .rd_data (cf_rdata)
  );

  // signed tap product
  assign mul_w = dl_rdata * cf_rdata;

  // saturating accumulate
  always_comb begin
    sum_w   = SW'(acc_r) + SW'(prod_r);
    acc_hi  = sum_w > AMAX_W;
    acc_lo  = sum_w < AMIN_W;
    acc_nxt = acc_hi ? AMAX_W[ACC_BITS-1:0] :
              acc_lo ? AMIN_W[ACC_BITS-1:0] : sum_w[ACC_BITS-1:0];
  end

  // round half up and clip to sample range
  always_comb begin
    rnd_sum   = $signed({acc_r[ACC_BITS-1], acc_r}) + $signed(RND_HALF);
    rnd_shift = rnd_sum >>> (SAMPLE_BITS - 1);
    rnd_hi    = rnd_shift > SMAX_W;
    rnd_lo    = rnd_shift < SMIN_W;
    res       = rnd_hi ? SMAX_W[SAMPLE_BITS-1:0] :
                rnd_lo ? SMIN_W[SAMPLE_BITS-1:0] : rnd_shift[SAMPLE_BITS-1:0];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      decim_r     <= DECIM_RESET;
      taps_cfg_r  <= TAPS_RESET;
      wp_r        <= '0;
      fill_r      <= '0;
      phase_r     <= '0;
      ptr_r       <= '0;
      k_r         <= '0;
      taps_r      <= '0;
      s1_v_r      <= 1'b0;
      s1_ok_r     <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (decim_wr) decim_r    <= cfg_wdata[DECIM_BITS-1:0];
      if (taps_wr)  taps_cfg_r <= cfg_wdata[TAPS_CFG_BITS-1:0];
      // sample beat: advance write pointer, fill count and phase
      if (smp_fire) begin
        wp_r <= (wp_r == LAST_ADDR) ? '0 : wp_r + AW'(1);
        if (fill_r != FULL_CNT) fill_r <= fill_r + CW'(1);
        phase_r <= (phase_inc >= {1'b0, dec_eff}) ? '0 : phase_inc[DECIM_BITS-1:0];
      end
      // tap walk, newest sample first
      if (start) begin
        ptr_r  <= wp_r;
        k_r    <= '0;
        taps_r <= taps_eff;
      end else if (issue) begin
        ptr_r <= (ptr_r == '0) ? LAST_ADDR : ptr_r - AW'(1);
        k_r   <= k_r + CW'(1);
      end
      s1_v_r  <= issue;
      s1_ok_r <= issue && (k_r < fill_r);
      s2_v_r  <= s1_v_r;
      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= s1_ok_r ? mul_w : '0;
    if (start) begin
      acc_r <= '0;
      sat_r <= 1'b0;
    end else if (s2_v_r) begin
      acc_r <= acc_nxt;
      sat_r <= sat_r || acc_hi || acc_lo;
    end
    if (load_out) begin
      out_filt_r <= res;
      out_sat_r  <= sat_r || rnd_hi || rnd_lo;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_filtered  = out_filt_r;
  assign out_saturated = out_sat_r;

endmodule

// ===== design/dfir_checker.sv =====
// dfir_checker: port-level assertions for the decimating fir filter
// depends on dfir_pkg; bound to decimating_fir_filter below
`timescale 1ns / 1ps

module dfir_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_mode,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_filtered,
  input logic                   out_saturated
);

  import dfir_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered) && $stable(out_saturated))
    else $error("result beat changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // a new result is only loaded while the sequencer is busy
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a filter run");

  // a coefficient beat leaves in_ready high
  a_coef_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_COEF) |=> in_ready)
    else $error("coefficient beat stalled the input");

endmodule

bind decimating_fir_filter dfir_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_dfir_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_mode       (in_mode),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_filtered  (out_filtered),
  .out_saturated (out_saturated)
);
